@@ hw/rtl/icw_pkg.sv @@
`default_nettype none

package icw_pkg;

  // Wheel geometry and id space.
  localparam int SLOTS         = 8;
  localparam int SLOT_CAPACITY = 16;
  localparam int ID_COUNT      = 1024;

  // Fixed field widths.
  localparam int ID_W    = 10;
  localparam int COUNT_W = 8;
  localparam int EV_W    = 2;

  // Derived widths.
  localparam int SLOT_AW  = $clog2(SLOTS);
  localparam int FILL_W   = $clog2(SLOT_CAPACITY + 1);
  localparam int ENT_AW   = $clog2(SLOTS * SLOT_CAPACITY);
  localparam int RC_DEPTH = (ID_COUNT > (1 << ID_W)) ? (1 << ID_W) : ID_COUNT;
  localparam int RC_AW    = $clog2(RC_DEPTH);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Item kinds.
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Result event codes.
  localparam logic [EV_W-1:0] EV_ACCEPT = 2'd0;
  localparam logic [EV_W-1:0] EV_DROP   = 2'd1;
  localparam logic [EV_W-1:0] EV_CLOSE  = 2'd2;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] conn_id;
  } in_item_t;

  typedef struct packed {
    logic [EV_W-1:0] event_res;
    logic [ID_W-1:0] result_id;
    logic            last;
  } out_item_t;

  // Access request to the reference count memory.
  typedef struct packed {
    logic               rd_en;
    logic [RC_AW-1:0]   rd_addr;
    logic               wr_en;
    logic [RC_AW-1:0]   wr_addr;
    logic [COUNT_W-1:0] wr_data;
  } rc_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/icw_refcnt.sv @@
`default_nettype none

// Reference count store: one write and one registered read per cycle. After
// reset it sweeps every entry to zero, one entry a cycle, while clearing is high.
module icw_refcnt
  import icw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rc_req_t            req,
  output logic [COUNT_W-1:0]      rd_data,
  output logic                    clearing
);

  logic [COUNT_W-1:0] mem [RC_DEPTH];
  logic [RC_AW-1:0]   clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == RC_AW'(RC_DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/idle_connection_timing_wheel.sv @@
`default_nettype none

// Idle-connection timing wheel.
//
// Input: an item is taken at a rising edge where start is high and busy is low.
// An add item (kind = add) files conn_id in the slot just behind the current
// one and raises that id's reference count; a tick item walks the current slot,
// lowers the count of every id listed there, closes each id whose count falls
// to zero, empties the slot and moves the wheel on by one slot.
// Output: each result beat is shown on result for exactly one cycle with strobe
// high. There is no back-pressure; the receiver must take every beat.
// Sequencing: an accepted add reads the id's count, then writes it back raised
// in S_ADD_WB (one read-modify-write of the count memory), registering its
// single beat there as the block returns to idle. A dropped add gives its beat
// in the cycle after acceptance and the block is ready again at once. A tick
// runs S_TK_CNT (count read) and S_TK_WB (count write-back, next entry read)
// per slot entry, then S_TK_END; close beats come out during the walk, the
// final one marked by last. A tick on an empty slot gives no beat, done at once.
// Reset: the count memory is swept to zero one entry a cycle, so busy stays high
// after reset until all RC_DEPTH (1024) entries are cleared. The wheel starts at
// slot 1 with every slot empty.
module idle_connection_timing_wheel
  import icw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  item,
  output logic           strobe,
  output out_item_t      result
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ADD_WB = 5'b00010,
    S_TK_CNT = 5'b00100,
    S_TK_WB  = 5'b01000,
    S_TK_END = 5'b10000
  } state_t;

  state_t              state;
  logic [SLOT_AW-1:0]  cur_slot;
  logic [FILL_W-1:0]   slot_fill [SLOTS];

  // Working registers of the item in progress.
  logic [ID_W-1:0]     op_id;
  logic [FILL_W-1:0]   op_fill;
  logic [FILL_W-1:0]   idx;

  // One close result is held back until we know whether it is the last.
  logic                pend_valid;
  logic [ID_W-1:0]     pend_id;

  // Slot entry store; its contents are only read below a slot's fill count.
  logic [ID_W-1:0]     ent_mem [SLOTS * SLOT_CAPACITY];
  logic [ID_W-1:0]     ent_rdata;
  logic                ent_we;
  logic [ENT_AW-1:0]   ent_waddr;
  logic                ent_re;
  logic [ENT_AW-1:0]   ent_raddr;

  rc_req_t             rc_req;
  logic [COUNT_W-1:0]  rc_rdata;
  logic                clearing;

  logic                accept;
  logic [SLOT_AW-1:0]  prev_slot;
  logic [SLOT_AW-1:0]  next_slot;
  logic [SLOT_AW-1:0]  sel_slot;
  logic [FILL_W-1:0]   sel_fill;
  logic                id_ok;
  logic                add_ok;
  logic                ent_ok;
  logic                hit;
  logic                close;
  logic                more;
  logic [FILL_W:0]     idx_inc;

  icw_refcnt u_refcnt (
    .clk      (clk),
    .rst      (rst),
    .req      (rc_req),
    .rd_data  (rc_rdata),
    .clearing (clearing)
  );

  assign busy   = clearing || (state != S_IDLE);
  assign accept = start && !busy;

  // Neighbouring slots of the current one, with wrap-around.
  assign prev_slot = (cur_slot == '0) ? SLOT_AW'(SLOTS - 1) : cur_slot - 1'b1;
  assign next_slot = (cur_slot == SLOT_AW'(SLOTS - 1)) ? '0 : cur_slot + 1'b1;

  // The fill counters have a single read port: an add looks at the slot behind,
  // a tick at the current slot.
  assign sel_slot = (item.kind == KIND_TICK) ? cur_slot : prev_slot;
  assign sel_fill = slot_fill[sel_slot];

  assign id_ok  = 32'(item.conn_id) < ID_COUNT;
  assign add_ok = id_ok && (32'(sel_fill) < SLOT_CAPACITY);

  // Walk bookkeeping for the tick in progress.
  assign ent_ok  = 32'(op_id) < ID_COUNT;
  assign hit     = ent_ok && (rc_rdata != '0);
  assign close   = hit && (rc_rdata == COUNT_W'(1));
  assign idx_inc = {1'b0, idx} + 1'b1;
  assign more    = idx_inc < {1'b0, op_fill};

  always_comb begin
    ent_we    = accept && (item.kind == KIND_ADD) && add_ok;
    ent_waddr = ENT_AW'(prev_slot) * ENT_AW'(SLOT_CAPACITY) + ENT_AW'(sel_fill);
    ent_re    = 1'b0;
    ent_raddr = ENT_AW'(cur_slot) * ENT_AW'(SLOT_CAPACITY);
    rc_req    = '0;

    if (accept) begin
      if (item.kind == KIND_ADD) begin
        rc_req.rd_en   = add_ok;
        rc_req.rd_addr = item.conn_id[RC_AW-1:0];
      end else begin
        ent_re = (sel_fill != '0);
      end
    end

    case (state)
      S_ADD_WB: begin
        rc_req.wr_en   = 1'b1;
        rc_req.wr_addr = op_id[RC_AW-1:0];
        rc_req.wr_data = (rc_rdata == COUNT_MAX) ? rc_rdata : rc_rdata + 1'b1;
      end
      S_TK_CNT: begin
        rc_req.rd_en   = 1'b1;
        rc_req.rd_addr = ent_rdata[RC_AW-1:0];
      end
      S_TK_WB: begin
        rc_req.wr_en   = hit;
        rc_req.wr_addr = op_id[RC_AW-1:0];
        rc_req.wr_data = rc_rdata - 1'b1;
        ent_re         = more;
        ent_raddr      = ENT_AW'(cur_slot) * ENT_AW'(SLOT_CAPACITY)
                         + ENT_AW'(idx_inc);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= item.conn_id;
    end
    if (ent_re) begin
      ent_rdata <= ent_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_slot   <= SLOT_AW'(1 % SLOTS);
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        slot_fill[s] <= '0;
      end
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.kind == KIND_ADD) begin
              op_id <= item.conn_id;
              if (add_ok) begin
                slot_fill[prev_slot] <= sel_fill + 1'b1;
                state                <= S_ADD_WB;
              end else begin
                strobe           <= 1'b1;
                result.event_res <= EV_DROP;
                result.result_id <= item.conn_id;
                result.last      <= 1'b1;
              end
            end else if (sel_fill == '0) begin
              // Nothing filed in this slot: just move the wheel on.
              cur_slot <= next_slot;
            end else begin
              op_fill <= sel_fill;
              idx     <= '0;
              state   <= S_TK_CNT;
            end
          end
        end
        S_ADD_WB: begin
          strobe           <= 1'b1;
          result.event_res <= EV_ACCEPT;
          result.result_id <= op_id;
          result.last      <= 1'b1;
          state            <= S_IDLE;
        end
        S_TK_CNT: begin
          op_id <= ent_rdata;
          state <= S_TK_WB;
        end
        S_TK_WB: begin
          if (close) begin
            if (pend_valid) begin
              strobe           <= 1'b1;
              result.event_res <= EV_CLOSE;
              result.result_id <= pend_id;
              result.last      <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_id    <= op_id;
          end
          if (more) begin
            idx   <= idx_inc[FILL_W-1:0];
            state <= S_TK_CNT;
          end else begin
            state <= S_TK_END;
          end
        end
        S_TK_END: begin
          if (pend_valid) begin
            strobe           <= 1'b1;
            result.event_res <= EV_CLOSE;
            result.result_id <= pend_id;
            result.last      <= 1'b1;
          end
          pend_valid          <= 1'b0;
          slot_fill[cur_slot] <= '0;
          cur_slot            <= next_slot;
          state               <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
